// ===== rtl/tsn_pkg.sv =====
package tsn_pkg;

  // default sizes
  localparam int NEURONS_DEF    = 512;
  localparam int MAX_FANOUT_DEF = 64;

  // field widths
  localparam int KIND_W   = 3;
  localparam int NEURON_W = 9;
  localparam int SLOT_W   = 6;
  localparam int TARGET_W = 9;
  localparam int WEIGHT_W = 16;
  localparam int COUNT_W  = 7;
  localparam int LEVEL_W  = 24;
  localparam int FIRED_W  = 10;
  localparam int LIMIT_W  = 10;
  localparam int LINK_W   = TARGET_W + WEIGHT_W;

  // stream and config widths
  localparam int IN_FIELDS_W  = NEURON_W + SLOT_W + TARGET_W + WEIGHT_W + COUNT_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = LEVEL_W + FIRED_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = LEVEL_W;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_COUNT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_LINK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STEP       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INIT       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SENSING_LIMIT = 1'b1;

  // register reset values
  localparam logic signed [LEVEL_W-1:0] THRESHOLD_RST     = 24'sd1;
  localparam logic [LIMIT_W-1:0]        SENSING_LIMIT_RST = 10'd512;

  // level saturation bounds
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [NEURON_W-1:0]        neuron;
    logic [SLOT_W-1:0]          slot;
    logic [TARGET_W-1:0]        target;
    logic signed [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]         count;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [LEVEL_W-1:0] level;
    logic [FIRED_W-1:0]        fired;
  } result_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] threshold;
    logic [LIMIT_W-1:0]        sensing_limit;
  } cfg_t;

endpackage

// ===== rtl/tsn_core.sv =====
module tsn_core #(
  parameter int NEURONS    = tsn_pkg::NEURONS_DEF,
  parameter int MAX_FANOUT = tsn_pkg::MAX_FANOUT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  tsn_pkg::cfg_t   cfg,
  input  tsn_pkg::item_t  item,
  input  logic            item_valid,
  output logic            item_ready,
  output tsn_pkg::result_t res,
  output logic            res_valid,
  input  logic            res_ready
);
  import tsn_pkg::*;

  localparam int NIDX_W  = $clog2(NEURONS);
  localparam int NCNT_W  = $clog2(NEURONS + 1);
  localparam int CW      = (NCNT_W > 10) ? NCNT_W : 10;
  localparam int LINK_AW = $clog2(NEURONS * MAX_FANOUT);
  localparam int LINKS   = NEURONS * MAX_FANOUT;
  localparam logic [NIDX_W-1:0] A_LAST = NIDX_W'(NEURONS - 1);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_EXEC      = 4'd2;
  localparam logic [3:0] S_READ_WAIT = 4'd3;
  localparam logic [3:0] S_INIT      = 4'd4;
  localparam logic [3:0] S_SCAN_RD   = 4'd5;
  localparam logic [3:0] S_SCAN_CHK  = 4'd6;
  localparam logic [3:0] S_LINK_NRD  = 4'd7;
  localparam logic [3:0] S_LINK_ACC  = 4'd8;
  localparam logic [3:0] S_COPY      = 4'd9;
  localparam logic [3:0] S_COPY_END  = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  // memories
  logic signed [LEVEL_W-1:0] level_mem [NEURONS];
  logic signed [LEVEL_W-1:0] next_mem  [NEURONS];
  logic [COUNT_W-1:0]        fan_mem   [NEURONS];
  logic [LINK_W-1:0]         link_mem  [LINKS];

  // memory ports
  logic                      level_we;
  logic [NIDX_W-1:0]         level_waddr, level_raddr;
  logic signed [LEVEL_W-1:0] level_wdata, level_rd;
  logic                      next_we;
  logic [NIDX_W-1:0]         next_waddr, next_raddr;
  logic signed [LEVEL_W-1:0] next_wdata, next_rd;
  logic                      fan_we;
  logic [NIDX_W-1:0]         fan_waddr, fan_raddr;
  logic [COUNT_W-1:0]        fan_wdata, fan_rd;
  logic                      link_we;
  logic [LINK_AW-1:0]        link_waddr, link_raddr;
  logic [LINK_W-1:0]         link_wdata, link_rd;

  // control and working registers
  logic [3:0]                state;
  item_t                     item_q;
  logic [NIDX_W-1:0]         a;
  logic [NCNT_W-1:0]         i;
  logic [COUNT_W-1:0]        j, n;
  logic [FIRED_W-1:0]        fired;
  logic signed [LEVEL_W-1:0] res_level;
  logic [LINK_AW-1:0]        link_addr;
  logic                      t_ok;
  logic [NIDX_W-1:0]         t_addr;
  logic signed [WEIGHT_W-1:0] w_q;
  logic                      wb_valid;
  logic [NIDX_W-1:0]         wb_addr;

  // derived values
  logic                      neuron_ok, slot_ok, tgt_ok, fire, scan_last, more_links;
  logic [NIDX_W-1:0]         neuron_idx, i_idx;
  logic [NCNT_W-1:0]         i_inc;
  logic [CW-1:0]             lim;
  logic [LINK_AW-1:0]        link_base;
  logic [TARGET_W-1:0]       lk_target;
  logic signed [WEIGHT_W-1:0] lk_weight;
  logic signed [LEVEL_W:0]   acc_sum;
  logic signed [LEVEL_W-1:0] acc_sat;
  logic [COUNT_W-1:0]        count_sat;

  assign neuron_ok  = CW'(item_q.neuron) < CW'(NEURONS);
  assign slot_ok    = 9'(item_q.slot) < 9'(MAX_FANOUT);
  assign neuron_idx = NIDX_W'(item_q.neuron);
  assign i_idx      = i[NIDX_W-1:0];
  assign i_inc      = i + 1'b1;
  assign lim        = (CW'(cfg.sensing_limit) > CW'(NEURONS)) ? CW'(NEURONS)
                                                             : CW'(cfg.sensing_limit);
  assign scan_last  = CW'(i_inc) == lim;
  assign more_links = ({1'b0, j} + 1'b1) < {1'b0, n};
  assign fire       = $signed(level_rd) >= $signed(cfg.threshold);
  assign link_base  = LINK_AW'(i_idx) * LINK_AW'(MAX_FANOUT);
  assign lk_target  = link_rd[LINK_W-1:WEIGHT_W];
  assign lk_weight  = $signed(link_rd[WEIGHT_W-1:0]);
  assign tgt_ok     = CW'(lk_target) < CW'(NEURONS);
  assign count_sat  = (9'(item_q.count) > 9'(MAX_FANOUT)) ? COUNT_W'(MAX_FANOUT)
                                                          : item_q.count;

  // saturating accumulate into the next level
  always_comb begin
    acc_sum = {next_rd[LEVEL_W-1], next_rd}
            + {{(LEVEL_W + 1 - WEIGHT_W){w_q[WEIGHT_W-1]}}, w_q};
    if (acc_sum[LEVEL_W] != acc_sum[LEVEL_W-1]) begin
      acc_sat = acc_sum[LEVEL_W] ? LEVEL_MIN : LEVEL_MAX;
    end else begin
      acc_sat = acc_sum[LEVEL_W-1:0];
    end
  end

  // memory port control
  always_comb begin
    level_we    = 1'b0;
    level_waddr = a;
    level_wdata = '0;
    next_we     = 1'b0;
    next_waddr  = a;
    next_wdata  = '0;
    fan_we      = 1'b0;
    fan_waddr   = a;
    fan_wdata   = '0;
    link_we     = 1'b0;
    link_waddr  = LINK_AW'(neuron_idx) * LINK_AW'(MAX_FANOUT) + LINK_AW'(item_q.slot);
    link_wdata  = {item_q.target, item_q.weight};
    level_raddr = (state == S_EXEC) ? neuron_idx : i_idx;
    fan_raddr   = i_idx;
    next_raddr  = (state == S_COPY) ? a : NIDX_W'(lk_target);
    link_raddr  = (state == S_SCAN_CHK) ? link_base : link_addr + 1'b1;
    unique case (state)
      S_CLEAR: begin
        level_we = 1'b1;
        next_we  = 1'b1;
        fan_we   = 1'b1;
      end
      S_EXEC: begin
        if (item_q.kind == KIND_LOAD_COUNT && neuron_ok) begin
          fan_we    = 1'b1;
          fan_waddr = neuron_idx;
          fan_wdata = count_sat;
        end
        if (item_q.kind == KIND_LOAD_LINK && neuron_ok && slot_ok) begin
          link_we = 1'b1;
        end
      end
      S_INIT: begin
        level_we    = 1'b1;
        level_wdata = cfg.threshold;
      end
      S_LINK_ACC: begin
        next_we    = t_ok;
        next_waddr = t_addr;
        next_wdata = acc_sat;
      end
      default: begin
      end
    endcase
    // copy write-back, next entry cleared for the following step
    if (wb_valid) begin
      level_we    = 1'b1;
      level_waddr = wb_addr;
      level_wdata = next_rd;
      next_we     = 1'b1;
      next_waddr  = wb_addr;
      next_wdata  = '0;
    end
  end

  // level store
  always_ff @(posedge clk) begin
    if (level_we) begin
      level_mem[level_waddr] <= level_wdata;
    end
    level_rd <= level_mem[level_raddr];
  end

  // next level store
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd <= next_mem[next_raddr];
  end

  // fanout store
  always_ff @(posedge clk) begin
    if (fan_we) begin
      fan_mem[fan_waddr] <= fan_wdata;
    end
    fan_rd <= fan_mem[fan_raddr];
  end

  // link store
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd <= link_mem[link_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      a        <= '0;
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          a <= a + 1'b1;
          if (a == A_LAST) begin
            a     <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            item_q <= item;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_level <= '0;
          fired     <= '0;
          i         <= '0;
          a         <= '0;
          case (item_q.kind)
            KIND_STEP: state <= (lim == '0) ? S_COPY : S_SCAN_RD;
            KIND_INIT: state <= S_INIT;
            KIND_READ: state <= S_READ_WAIT;
            default:   state <= S_DONE;
          endcase
        end
        S_READ_WAIT: begin
          if (neuron_ok) begin
            res_level <= level_rd;
          end
          state <= S_DONE;
        end
        S_INIT: begin
          a <= a + 1'b1;
          if (a == A_LAST) begin
            a     <= '0;
            state <= S_DONE;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (fire) begin
            if (fired != '1) begin
              fired <= fired + 1'b1;
            end
            n         <= fan_rd;
            j         <= '0;
            link_addr <= link_base;
          end
          if (fire && fan_rd != '0) begin
            state <= S_LINK_NRD;
          end else if (scan_last) begin
            state <= S_COPY;
          end else begin
            i     <= i_inc;
            state <= S_SCAN_RD;
          end
        end
        S_LINK_NRD: begin
          t_ok   <= tgt_ok;
          t_addr <= NIDX_W'(lk_target);
          w_q    <= lk_weight;
          state  <= S_LINK_ACC;
        end
        S_LINK_ACC: begin
          if (more_links) begin
            j         <= j + 1'b1;
            link_addr <= link_addr + 1'b1;
            state     <= S_LINK_NRD;
          end else if (scan_last) begin
            state <= S_COPY;
          end else begin
            i     <= i_inc;
            state <= S_SCAN_RD;
          end
        end
        S_COPY: begin
          wb_valid <= 1'b1;
          wb_addr  <= a;
          a        <= a + 1'b1;
          if (a == A_LAST) begin
            a     <= '0;
            state <= S_COPY_END;
          end
        end
        S_COPY_END: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result side
  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res.kind   = item_q.kind;
  assign res.level  = res_level;
  assign res.fired  = fired;

  // write-back only while copying
  a_wb_in_copy: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> (state == S_COPY || state == S_COPY_END))
    else $error("copy write-back outside copy phase");

  // link walk stays inside the loaded count
  a_link_in_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK_NRD) |-> ({1'b0, j} < {1'b0, n}))
    else $error("link index beyond fanout count");

  // fired count bounded by the neuron count
  a_fired_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (CW'(fired) <= CW'(NEURONS)))
    else $error("fired count above neuron count");

  // clearing pass runs to its end
  a_clear_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && a != A_LAST) |=> (state == S_CLEAR))
    else $error("clearing pass cut short");

endmodule

// ===== rtl/threshold_spiking_network_step.sv =====
// Threshold spiking network with one request per stream item and one result per request.
// Neuron levels, next levels, fanout counts and the connection table live in synchronous
// memories with one read and one write port; a sequencer reads, modifies and writes them
// back. After reset a clearing pass zeroes the level, next-level and fanout stores
// before the first request is taken (config writes are taken throughout). A step
// reads the level and fanout of each neuron below the effective sensing limit;
// each connection of a neuron that fires costs a link read then a next-level
// read-modify-write, and the final copy of next levels into levels sweeps one entry
// per cycle. One request is in work at a time; a finished result waits in the output
// register while the next request is accepted.
module threshold_spiking_network_step #(
  parameter int NEURONS    = tsn_pkg::NEURONS_DEF,
  parameter int MAX_FANOUT = tsn_pkg::MAX_FANOUT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tsn_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tsn_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // neuron[8:0], slot[14:9], target[23:15], weight[39:24], count[46:40], zero pad
  input  logic [tsn_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind[2:0]
  input  logic [tsn_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // neuron_level[23:0], fired_count[33:24], zero pad
  output logic [tsn_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // done_kind[2:0]
  output logic [tsn_pkg::KIND_W-1:0]       m_axis_tuser
);
  import tsn_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    res_valid, res_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= THRESHOLD_RST;
      cfg.sensing_limit <= SENSING_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:     cfg.threshold     <= $signed(cfg_wdata[LEVEL_W-1:0]);
        CFG_SENSING_LIMIT: cfg.sensing_limit <= cfg_wdata[LIMIT_W-1:0];
      endcase
    end
  end

  // unpack request
  always_comb begin
    item.kind   = s_axis_tuser;
    item.neuron = s_axis_tdata[NEURON_W-1:0];
    item.slot   = s_axis_tdata[NEURON_W +: SLOT_W];
    item.target = s_axis_tdata[NEURON_W + SLOT_W +: TARGET_W];
    item.weight = $signed(s_axis_tdata[NEURON_W + SLOT_W + TARGET_W +: WEIGHT_W]);
    item.count  = s_axis_tdata[NEURON_W + SLOT_W + TARGET_W + WEIGHT_W +: COUNT_W];
  end

  tsn_core #(
    .NEURONS    (NEURONS),
    .MAX_FANOUT (MAX_FANOUT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_valid (s_axis_tvalid),
    .item_ready (s_axis_tready),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tuser <= res.kind;
      m_axis_tdata <= {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, res.fired, res.level};
    end
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsn_pkg::*;

  localparam int NEURONS     = NEURONS_DEF;
  localparam int MAX_FANOUT  = MAX_FANOUT_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SEGMENT_REQ = 20;

  // kinds the block does not know, answered with an echo only
  localparam logic [KIND_W-1:0] KIND_RESERVED_FIRST = 3'd5;

  // mirror of the network state, predicts one result per request
  class net_scoreboard;
    int      threshold;
    int      sensing_limit;
    int      level_now [NEURONS];
    int      fanout [NEURONS];
    int      link_target [NEURONS*MAX_FANOUT];
    int      link_weight [NEURONS*MAX_FANOUT];
    bit      link_written [NEURONS*MAX_FANOUT];
    result_t awaited_outcomes [$];
    int      errors;

    function new();
      threshold     = int'(THRESHOLD_RST);
      sensing_limit = int'(SENSING_LIMIT_RST);
      foreach (level_now[i]) level_now[i] = 0;
      foreach (fanout[i]) fanout[i] = 0;
      foreach (link_written[i]) begin
        link_written[i] = 1'b0;
        link_target[i]  = 0;
        link_weight[i]  = 0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_THRESHOLD) begin
        threshold = int'($signed(value[LEVEL_W-1:0]));
      end else if (idx == CFG_SENSING_LIMIT) begin
        sensing_limit = int'(value[LIMIT_W-1:0]);
      end
    endfunction

    // slots written without a hole, counted from slot zero
    function int written_prefix(int n);
      int p;
      p = 0;
      while (p < MAX_FANOUT && link_written[n*MAX_FANOUT + p]) p++;
      return p;
    endfunction

    // first neuron that would fire and walk an unwritten connection
    function int unsafe_source();
      int lim;
      lim = (sensing_limit > NEURONS) ? NEURONS : sensing_limit;
      for (int i = 0; i < lim; i++) begin
        if (level_now[i] >= threshold && fanout[i] > written_prefix(i)) return i;
      end
      return -1;
    endfunction

    // apply one accepted request and queue its result
    function void note_request(item_t it);
      result_t want;
      int      lim;
      int      fired;
      int      idx;
      int      t;
      int      s;
      int      next_level [NEURONS];
      want.kind  = it.kind;
      want.level = '0;
      want.fired = '0;
      idx = int'(it.neuron) * MAX_FANOUT + int'(it.slot);
      case (it.kind)
        KIND_LOAD_COUNT: begin
          if (it.neuron < NEURONS)
            fanout[it.neuron] = (it.count > MAX_FANOUT) ? MAX_FANOUT : int'(it.count);
        end
        KIND_LOAD_LINK: begin
          if (it.neuron < NEURONS && it.slot < MAX_FANOUT) begin
            link_target[idx]  = int'(it.target);
            link_weight[idx]  = int'(it.weight);
            link_written[idx] = 1'b1;
          end
        end
        KIND_STEP: begin
          lim   = (sensing_limit > NEURONS) ? NEURONS : sensing_limit;
          fired = 0;
          foreach (next_level[i]) next_level[i] = 0;
          // sources ascending, slots ascending, each add saturates
          for (int i = 0; i < lim; i++) begin
            if (level_now[i] >= threshold) begin
              fired++;
              for (int j = 0; j < fanout[i]; j++) begin
                t = link_target[i*MAX_FANOUT + j];
                if (t < NEURONS) begin
                  s = next_level[t] + link_weight[i*MAX_FANOUT + j];
                  if (s > LEVEL_MAX) s = LEVEL_MAX;
                  if (s < LEVEL_MIN) s = LEVEL_MIN;
                  next_level[t] = s;
                end
              end
            end
          end
          level_now  = next_level;
          want.fired = FIRED_W'((fired > 1023) ? 1023 : fired);
        end
        KIND_INIT: begin
          foreach (level_now[i]) level_now[i] = threshold;
        end
        KIND_READ: begin
          if (it.neuron < NEURONS) want.level = LEVEL_W'(level_now[it.neuron]);
        end
        default: ;
      endcase
      awaited_outcomes.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_outcomes.size() == 0) begin
        $error("result with no request waiting: done_kind %0d", got.kind);
        errors++;
        return;
      end
      want = awaited_outcomes.pop_front();
      if (got.kind !== want.kind) begin
        $error("done_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.level !== want.level) begin
        $error("neuron_level: expected %0d, got %0d", want.level, got.level);
        errors++;
      end
      if (got.fired !== want.fired) begin
        $error("fired_count: expected %0d, got %0d", want.fired, got.fired);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [KIND_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;

  net_scoreboard sb;
  result_t       seen_result;
  int            send_idle_pct = 20;
  int            recv_idle_pct = 71;
  int            sent_count    = 0;
  int unsigned   cycle_count   = 0;

  threshold_spiking_network_step #(
    .NEURONS    (NEURONS),
    .MAX_FANOUT (MAX_FANOUT)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_result.kind  = m_axis_tuser;
      seen_result.level = m_axis_tdata[LEVEL_W-1:0];
      seen_result.fired = m_axis_tdata[LEVEL_W +: FIRED_W];
      sb.check_result(seen_result);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1:       return WEIGHT_W'($urandom);
      default: return WEIGHT_W'(int'($urandom_range(80)) - 20);
    endcase
  endfunction

  function automatic item_t random_request(logic [KIND_W-1:0] kind);
    item_t it;
    it.kind   = kind;
    it.neuron = NEURON_W'($urandom);
    it.slot   = SLOT_W'($urandom);
    it.target = TARGET_W'($urandom);
    it.weight = WEIGHT_W'($urandom);
    it.count  = COUNT_W'($urandom);
    return it;
  endfunction

  // one request on the input stream, with random idle cycles in front
  task automatic send_request(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= IN_DATA_W'({it.count, it.weight, it.target, it.slot, it.neuron});
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(it);
    sent_count++;
  endtask

  task automatic request(logic [KIND_W-1:0] kind, int neuron, int slot, int target,
                         int weight, int count);
    item_t it;
    it.kind   = kind;
    it.neuron = NEURON_W'(neuron);
    it.slot   = SLOT_W'(slot);
    it.target = TARGET_W'(target);
    it.weight = WEIGHT_W'(weight);
    it.count  = COUNT_W'(count);
    send_request(it);
  endtask

  // hold off the sender until every result is back, then let the block settle
  task automatic drain_results(int extra);
    s_axis_tvalid <= 1'b0;
    while (sb.awaited_outcomes.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, int value);
    drain_results(4);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, CFG_DATA_W'(value));
  endtask

  // trim counts that would walk unwritten connections, then step
  task automatic issue_step();
    item_t it;
    int    n;
    n = sb.unsafe_source();
    while (n >= 0) begin
      it        = random_request(KIND_LOAD_COUNT);
      it.neuron = NEURON_W'(n);
      it.count  = COUNT_W'(sb.written_prefix(n));
      send_request(it);
      n = sb.unsafe_source();
    end
    send_request(random_request(KIND_STEP));
  endtask

  // connection list of one source followed by its count
  task automatic wire_source(int src, int links, bit near);
    item_t it;
    int    prefix;
    for (int s = 0; s < links; s++) begin
      it        = random_request(KIND_LOAD_LINK);
      it.neuron = NEURON_W'(src);
      it.slot   = SLOT_W'(s);
      it.target = TARGET_W'(near ? $urandom_range(15) : $urandom_range(NEURONS-1));
      it.weight = random_weight();
      send_request(it);
    end
    prefix    = sb.written_prefix(src);
    it        = random_request(KIND_LOAD_COUNT);
    it.neuron = NEURON_W'(src);
    it.count  = COUNT_W'((prefix >= MAX_FANOUT) ? $urandom_range((1 << COUNT_W) - 1)
                                                : $urandom_range(prefix));
    send_request(it);
  endtask

  // random mix of network programs, reads, noise and pauses
  task automatic run_segment(int quota);
    item_t it;
    int    start;
    int    pick;
    int    src;
    start = sent_count;
    while (sent_count - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        src = ($urandom_range(3) == 0) ? $urandom_range(NEURONS-1) : $urandom_range(15);
        wire_source(src, $urandom_range(6, 1), $urandom_range(3) != 0);
      end else if (pick < 48) begin
        send_request(random_request(KIND_INIT));
      end else if (pick < 68) begin
        issue_step();
      end else if (pick < 86) begin
        it = random_request(KIND_READ);
        if ($urandom_range(2) != 0) it.neuron = NEURON_W'($urandom_range(15));
        send_request(it);
      end else if (pick < 94) begin
        it = random_request(KIND_W'($urandom_range(7)));
        if (it.kind == KIND_STEP) issue_step();
        else send_request(it);
      end else if (pick < 97) begin
        // count with no connection list behind it
        it        = random_request(KIND_LOAD_COUNT);
        it.neuron = NEURON_W'($urandom_range(15));
        send_request(it);
      end else begin
        drain_results(1);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reads after reset and unknown kinds
    request(KIND_READ, 0, 0, 0, 0, 0);
    request(KIND_READ, NEURONS-1, MAX_FANOUT-1, NEURONS-1, -1, (1 << COUNT_W) - 1);
    for (int k = 0; k < 3; k++)
      request(KIND_RESERVED_FIRST + KIND_W'(k), NEURONS-1, MAX_FANOUT-1, NEURONS-1, -1,
              (1 << COUNT_W) - 1);

    // small network with extreme weights and the last neuron as source
    request(KIND_LOAD_LINK, 1, 0, 2, -32768, 0);
    request(KIND_LOAD_LINK, 1, 1, NEURONS-1, 32767, 0);
    request(KIND_LOAD_COUNT, 1, 0, 0, 0, 2);
    request(KIND_LOAD_LINK, NEURONS-1, 0, 0, 5, 0);
    request(KIND_LOAD_COUNT, NEURONS-1, 0, 0, 0, 1);
    request(KIND_INIT, 0, 0, 0, 0, 0);
    issue_step();
    request(KIND_READ, 2, 0, 0, 0, 0);
    request(KIND_READ, NEURONS-1, 0, 0, 0, 0);
    request(KIND_READ, 0, 0, 0, 0, 0);
    issue_step();
    request(KIND_READ, 0, 0, 0, 0, 0);

    // highest threshold, nobody may fire
    write_register(CFG_THRESHOLD, int'(LEVEL_MAX));
    write_register(CFG_SENSING_LIMIT, 0);
    request(KIND_INIT, 0, 0, 0, 0, 0);
    issue_step();
    request(KIND_READ, 5, 0, 0, 0, 0);

    // lowest threshold, sensing limit above the neuron count
    write_register(CFG_THRESHOLD, int'(LEVEL_MIN));
    write_register(CFG_SENSING_LIMIT, (1 << LIMIT_W) - 1);
    request(KIND_INIT, 0, 0, 0, 0, 0);
    issue_step();
    request(KIND_READ, 2, 0, 0, 0, 0);

    // zero threshold, only the first neuron may fire
    write_register(CFG_THRESHOLD, 0);
    write_register(CFG_SENSING_LIMIT, 1);
    request(KIND_INIT, 0, 0, 0, 0, 0);
    issue_step();
    request(KIND_READ, 2, 0, 0, 0, 0);

    // short fanout lists with extreme weights summing onto two targets
    write_register(CFG_THRESHOLD, 1);
    write_register(CFG_SENSING_LIMIT, 10);
    for (int src = 0; src < 2; src++) begin
      for (int s = 0; s < 4; s++) begin
        if (s % 2 == 1) request(KIND_LOAD_LINK, src, s, 8, -32768, 0);
        else request(KIND_LOAD_LINK, src, s, 7, 32767, 0);
      end
      request(KIND_LOAD_COUNT, src, 0, 0, 0, 4);
    end
    request(KIND_INIT, 0, 0, 0, 0, 0);
    issue_step();
    request(KIND_READ, 7, 0, 0, 0, 0);
    request(KIND_READ, 8, 0, 0, 0, 0);
    issue_step();
    request(KIND_READ, 7, 0, 0, 0, 0);

    // random programs under three idling patterns
    for (int seg = 0; seg < 3; seg++) begin
      drain_results(4);
      case (seg)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_register(CFG_THRESHOLD, int'($urandom_range(10)) - 2);
      case (seg)
        0:       write_register(CFG_SENSING_LIMIT, NEURONS);
        1:       write_register(CFG_SENSING_LIMIT, $urandom_range((1 << LIMIT_W) - 1));
        default: write_register(CFG_SENSING_LIMIT, 16);
      endcase
      run_segment(SEGMENT_REQ);
    end

    // wait out every result and any stray one after it
    drain_results(NEURONS + 16);
    if (sb.errors == 0 && sb.awaited_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
